// File: src/ftprd_pkg.sv
// Shared types and constants for the FTP reply end detector.
`default_nettype none
package ftprd_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int LENGTH_WIDTH        = 16;
    localparam int CODE_WIDTH          = 10;
    localparam int COL_WIDTH           = 6;
    localparam int QUIRK_WIDTH         = 4;
    localparam int OUT_DATA_WIDTH      = 32;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [CODE_WIDTH-1:0] CODE_SPURIOUS = 10'd550;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_BIG_U = 8'h55;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_F     = 8'h66;

    localparam logic [COL_WIDTH-1:0] COL_MAX      = 6'd63;
    localparam logic [COL_WIDTH-1:0] COL_CODE_END = 6'd3;
    localparam logic [COL_WIDTH-1:0] OFF_START    = 6'd4;
    localparam logic [COL_WIDTH-1:0] OFF_SIG_0    = 6'd4;
    localparam logic [COL_WIDTH-1:0] OFF_SIG_1    = 6'd5;
    localparam logic [COL_WIDTH-1:0] OFF_SIG_2    = 6'd28;
    localparam logic [COL_WIDTH-1:0] OFF_SIG_3    = 6'd33;
    localparam logic [QUIRK_WIDTH-1:0] QUIRK_ALL  = 4'hF;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic                    done;
        logic [CODE_WIDTH-1:0]   code;
        logic                    complete;
        logic [LENGTH_WIDTH-1:0] length;
    } result_t;

    typedef struct packed {
        logic                   valid;
        logic [CODE_WIDTH-1:0]  code;
        logic [COL_WIDTH-1:0]   offset;
        logic [QUIRK_WIDTH-1:0] quirk;
    } cand_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage
`default_nettype wire

// File: src/ftprd_in_stage.sv
// Input register stage for incoming reply words.
`default_nettype none
module ftprd_in_stage
    import ftprd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire in_word_t s_word,
    input  wire logic     advance,
    output logic          word_valid,
    output in_word_t      word
);

    logic     valid_reg, valid_next;
    in_word_t word_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg <= s_word;
        end
    end

endmodule
`default_nettype wire

// File: src/ftprd_tracker.sv
// Line and candidate tracking, reply end decision and reply state.
`default_nettype none
module ftprd_tracker
    import ftprd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire in_word_t word,
    output logic          res_valid,
    output result_t       res
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COL_WIDTH-1:0]   col_reg, col_next;
    logic [CODE_WIDTH-1:0]  lcode_reg, lcode_next;
    logic                   prefix_reg, prefix_next;
    cand_t                  cand0_reg, cand0_next;
    cand_t                  cand1_reg, cand1_next;
    logic                   first_reg, first_next;
    logic                   head_reg, head_next;
    logic [CODE_WIDTH-1:0]  held_reg, held_next;
    logic                   complete_reg, complete_next;

    logic [13:0] acc;
    logic        fresh;
    logic        done;
    logic        pick_ok;
    cand_t       pick;
    logic [7:0]  b;

    function automatic cand_t track(input cand_t c, input logic [7:0] v);
        cand_t r;
        r = c;
        if (c.valid) begin
            if (c.offset == OFF_SIG_0 && v == CH_BIG_U) r.quirk[0] = 1'b1;
            if (c.offset == OFF_SIG_1 && v == CH_N)     r.quirk[1] = 1'b1;
            if (c.offset == OFF_SIG_2 && v == CH_U)     r.quirk[2] = 1'b1;
            if (c.offset == OFF_SIG_3 && v == CH_F)     r.quirk[3] = 1'b1;
            if (c.offset != COL_MAX) r.offset = c.offset + 6'd1;
        end
        return r;
    endfunction

    assign b         = word.data;
    assign res_valid = (word.mode == MODE_BYTE) && word.last;
    assign acc       = {4'b0, lcode_reg} * 14'd10 + {10'b0, b[3:0]};

    always_comb begin
        count_next    = count_reg;
        col_next      = col_reg;
        lcode_next    = lcode_reg;
        prefix_next   = prefix_reg;
        cand0_next    = cand0_reg;
        cand1_next    = cand1_reg;
        first_next    = first_reg;
        head_next     = head_reg;
        held_next     = held_reg;
        complete_next = complete_reg;
        fresh         = 1'b0;
        done          = 1'b0;
        pick_ok       = 1'b0;
        pick          = '0;
        if (word.mode == MODE_CLEAR) begin
            count_next    = '0;
            col_next      = '0;
            lcode_next    = '0;
            prefix_next   = 1'b1;
            cand0_next    = '0;
            cand1_next    = '0;
            first_next    = 1'b1;
            head_next     = 1'b1;
            complete_next = 1'b0;
        end else begin
            if (count_reg < COUNT_WIDTH'(3) && !is_digit(b)) head_next = 1'b0;
            if (!(&count_reg)) count_next = count_reg + 1'b1;
            cand0_next = track(cand0_reg, b);
            cand1_next = track(cand1_reg, b);
            if (col_reg < COL_CODE_END) begin
                if (is_digit(b)) begin
                    lcode_next = acc[CODE_WIDTH-1:0];
                end else begin
                    prefix_next = 1'b0;
                end
            end else if (col_reg == COL_CODE_END && prefix_reg && (b == CH_SP || b == CH_NL)) begin
                cand1_next = cand0_next;
                cand0_next = '{valid: 1'b1, code: lcode_reg, offset: OFF_START, quirk: '0};
                fresh      = 1'b1;
            end
            if (b == CH_NL) begin
                col_next    = '0;
                lcode_next  = '0;
                prefix_next = 1'b1;
            end else if (col_reg != COL_MAX) begin
                col_next = col_reg + 6'd1;
            end
            if (word.last) begin
                if (b == CH_NL) begin
                    if (!fresh && cand0_next.valid) begin
                        pick_ok = 1'b1;
                        pick    = cand0_next;
                    end else if (fresh && cand1_next.valid) begin
                        pick_ok = 1'b1;
                        pick    = cand1_next;
                    end
                end
                if (pick_ok) begin
                    held_next = pick.code;
                    done      = 1'b1;
                    if (pick.code == CODE_SPURIOUS) begin
                        if (pick.quirk == QUIRK_ALL) begin
                            count_next    = '0;
                            col_next      = '0;
                            lcode_next    = '0;
                            prefix_next   = 1'b1;
                            cand0_next    = '0;
                            cand1_next    = '0;
                            head_next     = 1'b1;
                            complete_next = 1'b0;
                            done          = 1'b0;
                        end
                    end else begin
                        complete_next = 1'b1;
                    end
                end else if (first_reg && count_next >= COUNT_WIDTH'(3) && !head_next) begin
                    held_next = '0;
                    done      = 1'b1;
                end
                first_next = (count_next == '0);
            end
        end
    end

    assign res.done     = done;
    assign res.code     = held_next;
    assign res.complete = complete_next;
    assign res.length   = LENGTH_WIDTH'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            col_reg      <= '0;
            lcode_reg    <= '0;
            prefix_reg   <= 1'b1;
            cand0_reg    <= '0;
            cand1_reg    <= '0;
            first_reg    <= 1'b1;
            head_reg     <= 1'b1;
            held_reg     <= '0;
            complete_reg <= 1'b0;
        end else if (advance) begin
            count_reg    <= count_next;
            col_reg      <= col_next;
            lcode_reg    <= lcode_next;
            prefix_reg   <= prefix_next;
            cand0_reg    <= cand0_next;
            cand1_reg    <= cand1_next;
            first_reg    <= first_next;
            head_reg     <= head_next;
            held_reg     <= held_next;
            complete_reg <= complete_next;
        end
    end

endmodule
`default_nettype wire

// File: src/ftprd_out_stage.sv
// Result register stage driving the master-side stream.
`default_nettype none
module ftprd_out_stage
    import ftprd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t res,
    output logic         slot_free,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [OUT_DATA_WIDTH-1:0] m_tdata
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = {4'b0, res_reg.length, res_reg.complete, res_reg.code, res_reg.done};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

// File: src/ftp_reply_end_detector.sv
// Top level of the FTP reply end detector.
// Takes one reply byte a word and produces one result word for each byte that closes a chunk.
// A byte passes an input register, is folded into the line and candidate state by one stage of
// short logic, and its result lands in an output register, so a new word is accepted every
// cycle as long as the result side keeps taking words; a stalled result only holds back bytes
// that themselves end a chunk. A clear word (tuser high) empties the reply without producing a
// result. There is no clearing pass.
`default_nettype none
module ftp_reply_end_detector
    import ftprd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
    input  wire logic                      s_tlast,   // chunk_end
    input  wire logic                      s_tuser,   // [0] mode
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [OUT_DATA_WIDTH-1:0]      m_tdata    // [0] reply_done, [10:1] reply_code,
                                                      // [11] reply_complete,
                                                      // [27:12] reply_length, [31:28] zero
);

    in_word_t s_word;
    in_word_t word;
    logic     word_valid;
    logic     advance;
    logic     res_valid;
    result_t  res;
    logic     slot_free;

    assign s_word  = '{mode: s_tuser, data: s_tdata, last: s_tlast};
    assign advance = word_valid && (!res_valid || slot_free);

    ftprd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_word),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    ftprd_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    ftprd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// File: src/ftprd_checker.sv
// Port-level checks for the FTP reply end detector and their binding.
`default_nettype none
module ftprd_checker
    import ftprd_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [OUT_DATA_WIDTH-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("stream sides not idle after reset");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:1] <= 10'd999)
        else $error("reply code beyond three digits");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:28] == 4'd0)
        else $error("result word padding not zero");

endmodule

bind ftp_reply_end_detector ftprd_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
